// ===== rtl/frc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg
// shared constants, control struct and raised-cosine weight function
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int LEVEL_BITS      = 16;
    localparam int TIME_BITS       = 48;
    localparam int COS_TABLE_DEPTH = 256;
    localparam int LEN_BITS        = 32;
    localparam int REG_IDX_BITS    = 3;
    localparam int W_BITS          = 17;

    localparam logic [REG_IDX_BITS-1:0] REG_MODE         = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_START_LEVEL  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_END_LEVEL    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_START_TIME   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_FADE_LENGTH  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_CYCLE_LENGTH = 3'd5;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef struct packed {
        logic osc;
        logic early;
        logic fin;
        logic neg;
    } ctrl_t;

    // sin^2 weight in q16 from a turn fraction in q32
    function automatic logic [W_BITS-1:0] rc_weight(input logic [63:0] turn_in);
        logic [63:0] turn;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] w;
        logic [63:0] r;
        turn = turn_in;
        if (turn > (64'd1 << 31))
            turn = (64'd1 << 32) - turn;
        x  = (turn * PI_Q30) >> 32;
        x2 = (x * x) >> 30;
        h  = Q30_ONE;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd110;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
        s  = (x * h) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        w = (s * s) >> 30;
        if (w > Q30_ONE)
            w = Q30_ONE;
        r = (w + (64'd1 << 13)) >> 14;
        return r[W_BITS-1:0];
    endfunction

endpackage

// ===== rtl/fade_ramp_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fade_ramp_oscillator
// linear fade ramp and raised-cosine oscillator, one level per frame time
// ----------------------------------------------------------------------------
// pipeline: prep, long divider, phase divider and shape stages, DW = max(TIME_BITS, LEVEL_BITS+32)
//   being the dividend width of the bit-per-stage long divider
// throughput: one item per cycle; the whole pipeline holds while the output stalls
// reset: all stage valid bits clear, registers return to mode 0, levels 0,
//   start time 0, fade length 0, cycle length 1
module fade_ramp_oscillator #(
    parameter int LEVEL_BITS      = frc_pkg::LEVEL_BITS,
    parameter int TIME_BITS       = frc_pkg::TIME_BITS,
    parameter int COS_TABLE_DEPTH = frc_pkg::COS_TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               wr_en,
    input  logic [frc_pkg::REG_IDX_BITS-1:0]   wr_index,
    input  logic [TIME_BITS-1:0]               wr_data,
    // input items
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [TIME_BITS-1:0]               now_frame,
    // result items
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [LEVEL_BITS-1:0]       level,
    output logic                               finished
);
    localparam int LB   = frc_pkg::LEN_BITS;
    // long divider covers both the ramp product and the full elapsed time
    localparam int DW   = (TIME_BITS > LEVEL_BITS + LB) ? TIME_BITS : LEVEL_BITS + LB;
    localparam int IDXW = $clog2(COS_TABLE_DEPTH);

    // configuration registers
    logic                  mode_reg;
    logic [LEVEL_BITS-1:0] start_level_reg;
    logic [LEVEL_BITS-1:0] end_level_reg;
    logic [TIME_BITS-1:0]  start_time_reg;
    logic [LB-1:0]         fade_length_reg;
    logic [LB-1:0]         cycle_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 1'b0;
            start_level_reg  <= '0;
            end_level_reg    <= '0;
            start_time_reg   <= '0;
            fade_length_reg  <= '0;
            cycle_length_reg <= LB'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                frc_pkg::REG_MODE:         mode_reg         <= wr_data[0];
                frc_pkg::REG_START_LEVEL:  start_level_reg  <= wr_data[LEVEL_BITS-1:0];
                frc_pkg::REG_END_LEVEL:    end_level_reg    <= wr_data[LEVEL_BITS-1:0];
                frc_pkg::REG_START_TIME:   start_time_reg   <= wr_data;
                frc_pkg::REG_FADE_LENGTH:  fade_length_reg  <= wr_data[LB-1:0];
                frc_pkg::REG_CYCLE_LENGTH: cycle_length_reg <= wr_data[LB-1:0];
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    // single advance enable: every stage moves unless a finished item waits
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // prep -> divider
    logic                  pd_valid;
    frc_pkg::ctrl_t        pd_ctrl;
    logic [LEVEL_BITS-1:0] pd_from;
    logic [LEVEL_BITS-1:0] pd_dmag;
    logic [LB-1:0]         pd_den;
    logic [DW-1:0]         pd_dvd;

    frc_prep #(
        .LEVEL_BITS (LEVEL_BITS),
        .TIME_BITS  (TIME_BITS),
        .DW         (DW)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .now_frame    (now_frame),
        .mode         (mode_reg),
        .start_level  (start_level_reg),
        .end_level    (end_level_reg),
        .start_time   (start_time_reg),
        .fade_length  (fade_length_reg),
        .cycle_length (cycle_length_reg),
        .o_valid      (pd_valid),
        .o_ctrl       (pd_ctrl),
        .o_from       (pd_from),
        .o_dmag       (pd_dmag),
        .o_den        (pd_den),
        .o_dividend   (pd_dvd)
    );

    // divider -> phase: remainder is the phase before the floor wrap (oscillate) or the
    // rounding residue (ramp), quotient the ramp step
    logic                  dp_valid;
    frc_pkg::ctrl_t        dp_ctrl;
    logic [LEVEL_BITS-1:0] dp_from;
    logic [LEVEL_BITS-1:0] dp_dmag;
    logic [LB-1:0]         dp_den;
    logic [LB-1:0]         dp_rem;
    logic [LEVEL_BITS:0]   dp_quo;

    frc_long_div #(
        .LEVEL_BITS (LEVEL_BITS),
        .DW         (DW)
    ) u_long_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .i_valid    (pd_valid),
        .i_ctrl     (pd_ctrl),
        .i_from     (pd_from),
        .i_dmag     (pd_dmag),
        .i_den      (pd_den),
        .i_dividend (pd_dvd),
        .o_valid    (dp_valid),
        .o_ctrl     (dp_ctrl),
        .o_from     (dp_from),
        .o_dmag     (dp_dmag),
        .o_den      (dp_den),
        .o_rem      (dp_rem),
        .o_quo      (dp_quo)
    );

    // phase -> shape
    logic                  ps_valid;
    frc_pkg::ctrl_t        ps_ctrl;
    logic [LEVEL_BITS-1:0] ps_from;
    logic [LEVEL_BITS-1:0] ps_dmag;
    logic [LEVEL_BITS:0]   ps_qr;
    logic [IDXW-1:0]       ps_idx;

    frc_phase_div #(
        .LEVEL_BITS      (LEVEL_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .IDXW            (IDXW)
    ) u_phase_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .i_valid (dp_valid),
        .i_ctrl  (dp_ctrl),
        .i_from  (dp_from),
        .i_dmag  (dp_dmag),
        .i_den   (dp_den),
        .i_rem   (dp_rem),
        .i_quo   (dp_quo),
        .o_valid (ps_valid),
        .o_ctrl  (ps_ctrl),
        .o_from  (ps_from),
        .o_dmag  (ps_dmag),
        .o_qr    (ps_qr),
        .o_idx   (ps_idx)
    );

    // shape stage ends in the output register that holds while stalled
    logic [LEVEL_BITS-1:0] level_raw;

    frc_shape #(
        .LEVEL_BITS      (LEVEL_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .IDXW            (IDXW)
    ) u_shape (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .i_valid    (ps_valid),
        .i_ctrl     (ps_ctrl),
        .i_from     (ps_from),
        .i_dmag     (ps_dmag),
        .i_qr       (ps_qr),
        .i_idx      (ps_idx),
        .o_valid    (out_valid),
        .o_level    (level_raw),
        .o_finished (finished)
    );

    assign level = $signed(level_raw);

endmodule

// ===== rtl/frc_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_prep
// elapsed time, level difference, special cases and ramp product
// ----------------------------------------------------------------------------
module frc_prep #(
    parameter int LEVEL_BITS = frc_pkg::LEVEL_BITS,
    parameter int TIME_BITS  = frc_pkg::TIME_BITS,
    parameter int DW         = frc_pkg::TIME_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [TIME_BITS-1:0]           now_frame,
    input  logic                           mode,
    input  logic [LEVEL_BITS-1:0]          start_level,
    input  logic [LEVEL_BITS-1:0]          end_level,
    input  logic [TIME_BITS-1:0]           start_time,
    input  logic [frc_pkg::LEN_BITS-1:0]   fade_length,
    input  logic [frc_pkg::LEN_BITS-1:0]   cycle_length,
    output logic                           o_valid,
    output frc_pkg::ctrl_t                 o_ctrl,
    output logic [LEVEL_BITS-1:0]          o_from,
    output logic [LEVEL_BITS-1:0]          o_dmag,
    output logic [frc_pkg::LEN_BITS-1:0]   o_den,
    output logic [DW-1:0]                  o_dividend
);
    localparam int LB = frc_pkg::LEN_BITS;

    logic                  s1_valid_reg;
    frc_pkg::ctrl_t        s1_ctrl_reg, s1_ctrl_next;
    logic [LEVEL_BITS-1:0] s1_from_reg, s1_from_next;
    logic [LEVEL_BITS-1:0] s1_dmag_reg, s1_dmag_next;
    logic [LB-1:0]         s1_den_reg, s1_den_next;
    logic [TIME_BITS-1:0]  s1_mag_reg, s1_mag_next;

    logic                  s2_valid_reg;
    frc_pkg::ctrl_t        s2_ctrl_reg;
    logic [LEVEL_BITS-1:0] s2_from_reg;
    logic [LEVEL_BITS-1:0] s2_dmag_reg;
    logic [LB-1:0]         s2_den_reg;
    logic [DW-1:0]         s2_dvd_reg, s2_dvd_next;

    logic                  early;
    logic [LEVEL_BITS:0]   diff;
    logic [LEVEL_BITS:0]   diff_abs;
    logic [LEVEL_BITS+LB-1:0] ramp_prod;

    always_comb
    begin
        early        = now_frame < start_time;
        s1_mag_next  = early ? start_time - now_frame : now_frame - start_time;
        diff         = {end_level[LEVEL_BITS-1], end_level}
                     - {start_level[LEVEL_BITS-1], start_level};
        diff_abs     = diff[LEVEL_BITS] ? -diff : diff;
        s1_ctrl_next.osc    = mode;
        s1_ctrl_next.early  = early;
        s1_ctrl_next.neg    = diff[LEVEL_BITS];
        s1_ctrl_next.fin    = 1'b0;
        s1_from_next = start_level;
        s1_dmag_next = diff_abs[LEVEL_BITS-1:0];
        if (mode)
        begin
            s1_den_next = (cycle_length == '0) ? LB'(1) : cycle_length;
        end
        else
        begin
            s1_den_next = (fade_length == '0) ? LB'(1) : fade_length;
            // ramp over: end level, no interpolation
            if (fade_length == '0 || (!early && s1_mag_next >= TIME_BITS'(fade_length)))
            begin
                s1_ctrl_next.fin = 1'b1;
                s1_from_next     = end_level;
                s1_dmag_next     = '0;
            end
            else if (early)
            begin
                s1_dmag_next = '0;
            end
        end
    end

    always_comb
    begin
        ramp_prod = (LEVEL_BITS+LB)'(s1_dmag_reg) * (LEVEL_BITS+LB)'(s1_mag_reg[LB-1:0]);
        s2_dvd_next = s1_ctrl_reg.osc ? DW'(s1_mag_reg) : DW'(ramp_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s1_from_reg <= s1_from_next;
            s1_dmag_reg <= s1_dmag_next;
            s1_den_reg  <= s1_den_next;
            s1_mag_reg  <= s1_mag_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_from_reg <= s1_from_reg;
            s2_dmag_reg <= s1_dmag_reg;
            s2_den_reg  <= s1_den_reg;
            s2_dvd_reg  <= s2_dvd_next;
        end
    end

    assign o_valid    = s2_valid_reg;
    assign o_ctrl     = s2_ctrl_reg;
    assign o_from     = s2_from_reg;
    assign o_dmag     = s2_dmag_reg;
    assign o_den      = s2_den_reg;
    assign o_dividend = s2_dvd_reg;

endmodule

// ===== rtl/frc_long_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_long_div
// restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module frc_long_div #(
    parameter int LEVEL_BITS = frc_pkg::LEVEL_BITS,
    parameter int DW         = frc_pkg::TIME_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         i_valid,
    input  frc_pkg::ctrl_t               i_ctrl,
    input  logic [LEVEL_BITS-1:0]        i_from,
    input  logic [LEVEL_BITS-1:0]        i_dmag,
    input  logic [frc_pkg::LEN_BITS-1:0] i_den,
    input  logic [DW-1:0]                i_dividend,
    output logic                         o_valid,
    output frc_pkg::ctrl_t               o_ctrl,
    output logic [LEVEL_BITS-1:0]        o_from,
    output logic [LEVEL_BITS-1:0]        o_dmag,
    output logic [frc_pkg::LEN_BITS-1:0] o_den,
    output logic [frc_pkg::LEN_BITS-1:0] o_rem,
    output logic [LEVEL_BITS:0]          o_quo
);
    localparam int LB = frc_pkg::LEN_BITS;
    localparam int QW = LEVEL_BITS + 1;

    logic                  valid_reg [DW];
    frc_pkg::ctrl_t        ctrl_reg  [DW];
    logic [LEVEL_BITS-1:0] from_reg  [DW];
    logic [LEVEL_BITS-1:0] dmag_reg  [DW];
    logic [LB-1:0]         den_reg   [DW];
    logic [DW-1:0]         dvd_reg   [DW];
    logic [LB-1:0]         rem_reg   [DW];
    logic [QW-1:0]         quo_reg   [DW];

    for (genvar s = 0; s < DW; s++)
    begin : g_step
        logic                  cur_valid;
        frc_pkg::ctrl_t        cur_ctrl;
        logic [LEVEL_BITS-1:0] cur_from;
        logic [LEVEL_BITS-1:0] cur_dmag;
        logic [LB-1:0]         cur_den;
        logic [DW-1:0]         cur_dvd;
        logic [LB-1:0]         cur_rem;
        logic [QW-1:0]         cur_quo;
        logic [LB:0]           trial;
        logic                  ge;

        if (s == 0)
        begin : g_head
            assign cur_valid = i_valid;
            assign cur_ctrl  = i_ctrl;
            assign cur_from  = i_from;
            assign cur_dmag  = i_dmag;
            assign cur_den   = i_den;
            assign cur_dvd   = i_dividend;
            assign cur_rem   = '0;
            assign cur_quo   = '0;
        end
        else
        begin : g_body
            assign cur_valid = valid_reg[s-1];
            assign cur_ctrl  = ctrl_reg[s-1];
            assign cur_from  = from_reg[s-1];
            assign cur_dmag  = dmag_reg[s-1];
            assign cur_den   = den_reg[s-1];
            assign cur_dvd   = dvd_reg[s-1];
            assign cur_rem   = rem_reg[s-1];
            assign cur_quo   = quo_reg[s-1];
        end

        // partial remainder stays below the divisor, so 33 bits hold the trial
        assign trial = {cur_rem, cur_dvd[DW-1-s]};
        assign ge    = trial >= {1'b0, cur_den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctrl_reg[s] <= cur_ctrl;
                from_reg[s] <= cur_from;
                dmag_reg[s] <= cur_dmag;
                den_reg[s]  <= cur_den;
                dvd_reg[s]  <= cur_dvd;
                rem_reg[s]  <= ge ? LB'(trial - {1'b0, cur_den}) : LB'(trial);
                quo_reg[s]  <= {cur_quo[QW-2:0], ge};
            end
        end
    end

    assign o_valid = valid_reg[DW-1];
    assign o_ctrl  = ctrl_reg[DW-1];
    assign o_from  = from_reg[DW-1];
    assign o_dmag  = dmag_reg[DW-1];
    assign o_den   = den_reg[DW-1];
    assign o_rem   = rem_reg[DW-1];
    assign o_quo   = quo_reg[DW-1];

endmodule

// ===== rtl/frc_phase_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_phase_div
// phase wrap, ramp rounding and table index division
// ----------------------------------------------------------------------------
module frc_phase_div #(
    parameter int LEVEL_BITS      = frc_pkg::LEVEL_BITS,
    parameter int COS_TABLE_DEPTH = frc_pkg::COS_TABLE_DEPTH,
    parameter int IDXW            = $clog2(frc_pkg::COS_TABLE_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         i_valid,
    input  frc_pkg::ctrl_t               i_ctrl,
    input  logic [LEVEL_BITS-1:0]        i_from,
    input  logic [LEVEL_BITS-1:0]        i_dmag,
    input  logic [frc_pkg::LEN_BITS-1:0] i_den,
    input  logic [frc_pkg::LEN_BITS-1:0] i_rem,
    input  logic [LEVEL_BITS:0]          i_quo,
    output logic                         o_valid,
    output frc_pkg::ctrl_t               o_ctrl,
    output logic [LEVEL_BITS-1:0]        o_from,
    output logic [LEVEL_BITS-1:0]        o_dmag,
    output logic [LEVEL_BITS:0]          o_qr,
    output logic [IDXW-1:0]              o_idx
);
    localparam int LB = frc_pkg::LEN_BITS;
    localparam int NW = LB + IDXW;
    localparam int QW = LEVEL_BITS + 1;

    logic                  a_valid_reg;
    frc_pkg::ctrl_t        a_ctrl_reg;
    logic [LEVEL_BITS-1:0] a_from_reg;
    logic [LEVEL_BITS-1:0] a_dmag_reg;
    logic [LB-1:0]         a_den_reg;
    logic [QW-1:0]         a_qr_reg, a_qr_next;
    logic [NW-1:0]         a_num_reg, a_num_next;

    logic [LB-1:0]         wrap_r;
    logic                  round_up;

    always_comb
    begin
        // floor wrap: negative elapsed time folds up into the period
        wrap_r = i_rem;
        if (i_ctrl.early && i_rem != '0)
            wrap_r = i_den - i_rem;
        a_num_next = NW'(wrap_r) * NW'(COS_TABLE_DEPTH);
        round_up   = {i_rem, 1'b0} >= {1'b0, i_den};
        a_qr_next  = i_quo + QW'(round_up);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= i_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctrl_reg <= i_ctrl;
            a_from_reg <= i_from;
            a_dmag_reg <= i_dmag;
            a_den_reg  <= i_den;
            a_qr_reg   <= a_qr_next;
            a_num_reg  <= a_num_next;
        end
    end

    logic                  valid_reg [IDXW];
    frc_pkg::ctrl_t        ctrl_reg  [IDXW];
    logic [LEVEL_BITS-1:0] from_reg  [IDXW];
    logic [LEVEL_BITS-1:0] dmag_reg  [IDXW];
    logic [LB-1:0]         den_reg   [IDXW];
    logic [QW-1:0]         qr_reg    [IDXW];
    logic [IDXW-1:0]       low_reg   [IDXW];
    logic [LB-1:0]         rem_reg   [IDXW];
    logic [IDXW-1:0]       idx_reg   [IDXW];

    for (genvar k = 0; k < IDXW; k++)
    begin : g_step
        logic                  cur_valid;
        frc_pkg::ctrl_t        cur_ctrl;
        logic [LEVEL_BITS-1:0] cur_from;
        logic [LEVEL_BITS-1:0] cur_dmag;
        logic [LB-1:0]         cur_den;
        logic [QW-1:0]         cur_qr;
        logic [IDXW-1:0]       cur_low;
        logic [LB-1:0]         cur_rem;
        logic [IDXW-1:0]       cur_idx;
        logic [LB:0]           trial;
        logic                  ge;

        if (k == 0)
        begin : g_head
            assign cur_valid = a_valid_reg;
            assign cur_ctrl  = a_ctrl_reg;
            assign cur_from  = a_from_reg;
            assign cur_dmag  = a_dmag_reg;
            assign cur_den   = a_den_reg;
            assign cur_qr    = a_qr_reg;
            assign cur_low   = a_num_reg[IDXW-1:0];
            // upper part of r*depth is already below the period
            assign cur_rem   = a_num_reg[NW-1:IDXW];
            assign cur_idx   = '0;
        end
        else
        begin : g_body
            assign cur_valid = valid_reg[k-1];
            assign cur_ctrl  = ctrl_reg[k-1];
            assign cur_from  = from_reg[k-1];
            assign cur_dmag  = dmag_reg[k-1];
            assign cur_den   = den_reg[k-1];
            assign cur_qr    = qr_reg[k-1];
            assign cur_low   = low_reg[k-1];
            assign cur_rem   = rem_reg[k-1];
            assign cur_idx   = idx_reg[k-1];
        end

        assign trial = {cur_rem, cur_low[IDXW-1-k]};
        assign ge    = trial >= {1'b0, cur_den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctrl_reg[k] <= cur_ctrl;
                from_reg[k] <= cur_from;
                dmag_reg[k] <= cur_dmag;
                den_reg[k]  <= cur_den;
                qr_reg[k]   <= cur_qr;
                low_reg[k]  <= cur_low;
                rem_reg[k]  <= ge ? LB'(trial - {1'b0, cur_den}) : LB'(trial);
                idx_reg[k]  <= {cur_idx[IDXW-2:0], ge};
            end
        end
    end

    assign o_valid = valid_reg[IDXW-1];
    assign o_ctrl  = ctrl_reg[IDXW-1];
    assign o_from  = from_reg[IDXW-1];
    assign o_dmag  = dmag_reg[IDXW-1];
    assign o_qr    = qr_reg[IDXW-1];
    assign o_idx   = idx_reg[IDXW-1];

endmodule

// ===== rtl/frc_shape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_shape
// cosine weight lookup, weight product and final level
// ----------------------------------------------------------------------------
module frc_shape #(
    parameter int LEVEL_BITS      = frc_pkg::LEVEL_BITS,
    parameter int COS_TABLE_DEPTH = frc_pkg::COS_TABLE_DEPTH,
    parameter int IDXW            = $clog2(frc_pkg::COS_TABLE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  i_valid,
    input  frc_pkg::ctrl_t        i_ctrl,
    input  logic [LEVEL_BITS-1:0] i_from,
    input  logic [LEVEL_BITS-1:0] i_dmag,
    input  logic [LEVEL_BITS:0]   i_qr,
    input  logic [IDXW-1:0]       i_idx,
    output logic                  o_valid,
    output logic [LEVEL_BITS-1:0] o_level,
    output logic                  o_finished
);
    localparam int WB = frc_pkg::W_BITS;
    localparam int QW = LEVEL_BITS + 1;
    localparam int PW = LEVEL_BITS + WB;

    logic [WB-1:0] rom_tab [COS_TABLE_DEPTH];

    for (genvar i = 0; i < COS_TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] TURN = (64'(i) << 32) / COS_TABLE_DEPTH;
        assign rom_tab[i] = frc_pkg::rc_weight(TURN);
    end

    logic                  w_valid_reg;
    frc_pkg::ctrl_t        w_ctrl_reg;
    logic [LEVEL_BITS-1:0] w_from_reg;
    logic [LEVEL_BITS-1:0] w_dmag_reg;
    logic [QW-1:0]         w_qr_reg;
    logic [WB-1:0]         w_w_reg;

    logic                  p_valid_reg;
    frc_pkg::ctrl_t        p_ctrl_reg;
    logic [LEVEL_BITS-1:0] p_from_reg;
    logic [QW-1:0]         p_qr_reg;
    logic [PW-1:0]         p_prod_reg, p_prod_next;

    logic                  o_valid_reg;
    logic [LEVEL_BITS-1:0] o_level_reg, o_level_next;
    logic                  o_fin_reg;

    logic [QW-1:0]         q_osc;
    logic [QW-1:0]         q_sel;
    logic [LEVEL_BITS+1:0] from_ext;
    logic [LEVEL_BITS+1:0] q_ext;
    logic [LEVEL_BITS+1:0] sum;

    assign p_prod_next = PW'(w_dmag_reg) * PW'(w_w_reg);

    always_comb
    begin
        q_osc    = p_prod_reg[PW-1:16] + QW'(p_prod_reg[15]);
        q_sel    = p_ctrl_reg.osc ? q_osc : p_qr_reg;
        from_ext = {{2{p_from_reg[LEVEL_BITS-1]}}, p_from_reg};
        q_ext    = {1'b0, q_sel};
        sum      = p_ctrl_reg.neg ? from_ext - q_ext : from_ext + q_ext;
        o_level_next = sum[LEVEL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            w_valid_reg <= i_valid;
            p_valid_reg <= w_valid_reg;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_ctrl_reg  <= i_ctrl;
            w_from_reg  <= i_from;
            w_dmag_reg  <= i_dmag;
            w_qr_reg    <= i_qr;
            w_w_reg     <= rom_tab[i_idx];
            p_ctrl_reg  <= w_ctrl_reg;
            p_from_reg  <= w_from_reg;
            p_qr_reg    <= w_qr_reg;
            p_prod_reg  <= p_prod_next;
            o_level_reg <= o_level_next;
            o_fin_reg   <= p_ctrl_reg.fin;
        end
    end

    assign o_valid    = o_valid_reg;
    assign o_level    = o_level_reg;
    assign o_finished = o_fin_reg;

endmodule
